[rtl/ps2mpc_pkg.sv]
package ps2mpc_pkg;

    localparam int SCROLL_DIVISOR = 16;
    localparam int QUEUE_DEPTH    = 2;

    // Input operation codes.
    localparam logic OP_DATA  = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    // Result cause codes.
    localparam logic CAUSE_BUTTON = 1'b0;
    localparam logic CAUSE_DRAIN  = 1'b1;

    // Register index codes, decoded from paddr[2].
    localparam logic REG_WHEEL_ENABLED  = 1'b0;
    localparam logic REG_DELIVER_ENABLE = 1'b1;

    // Fields of the packet head byte.
    localparam logic [7:0] HEAD_SYNC_MASK = 8'h08;
    localparam logic [7:0] HEAD_OVF_MASK  = 8'hC0;
    localparam int         HEAD_XSIGN_BIT = 4;
    localparam int         HEAD_YSIGN_BIT = 5;
    localparam int         BUTTON_W       = 3;
    localparam int         SUM_W          = 16;

    typedef enum logic {
        KIND_PACKET = 1'b0,
        KIND_DRAIN  = 1'b1
    } t_kind;

    typedef struct packed {
        t_kind                 kind;
        logic [BUTTON_W-1:0]   buttons;
        logic [8:0]            dx;
        logic [8:0]            dy;
        logic [7:0]            wheel;
    } t_entry;

    typedef struct packed {
        logic wheel_enabled;
        logic deliver_enable;
    } t_cfg;

endpackage

[rtl/ps2mpc_front.sv]
module ps2mpc_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic                i_op,
    input  logic [7:0]          i_data_byte,
    input  ps2mpc_pkg::t_cfg    i_cfg,
    input  logic                i_queue_full,
    output logic                o_push,
    output ps2mpc_pkg::t_entry  o_entry
);

    logic [1:0] r_pos;
    logic [1:0] n_pos;
    logic [7:0] r_b0;
    logic [7:0] r_b1;
    logic [7:0] r_b2;

    logic accept;
    logic is_drain;
    logic bad_head;
    logic drop;
    logic complete;
    logic take_byte;

    assign o_stall = i_queue_full;
    assign accept  = i_valid & ~i_queue_full;

    always_comb begin
        is_drain  = (i_op == ps2mpc_pkg::OP_DRAIN);
        bad_head  = ((i_data_byte & ps2mpc_pkg::HEAD_SYNC_MASK) == 8'h00) ||
                    ((i_data_byte & ps2mpc_pkg::HEAD_OVF_MASK) != 8'h00);
        drop      = (r_pos == 2'd0) && bad_head;
        // Three-byte packets end at position 2; a position of 3 always ends a packet,
        // which covers the wheel being switched off partway through a packet.
        complete  = !drop && ((r_pos == 2'd3) || ((r_pos == 2'd2) && !i_cfg.wheel_enabled));
        take_byte = accept && !is_drain && !drop;

        n_pos = r_pos;
        if (take_byte) begin
            n_pos = complete ? 2'd0 : r_pos + 2'd1;
        end

        o_push = accept && (is_drain || complete);

        o_entry.kind    = is_drain ? ps2mpc_pkg::KIND_DRAIN : ps2mpc_pkg::KIND_PACKET;
        o_entry.buttons = r_b0[ps2mpc_pkg::BUTTON_W-1:0];
        o_entry.dx      = {r_b0[ps2mpc_pkg::HEAD_XSIGN_BIT], r_b1};
        o_entry.dy      = {r_b0[ps2mpc_pkg::HEAD_YSIGN_BIT],
                           (r_pos == 2'd2) ? i_data_byte : r_b2};
        o_entry.wheel   = i_cfg.wheel_enabled ? i_data_byte : 8'h00;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= 2'd0;
        end else begin
            r_pos <= n_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take_byte) begin
            case (r_pos)
                2'd0:    r_b0 <= i_data_byte;
                2'd1:    r_b1 <= i_data_byte;
                2'd2:    r_b2 <= i_data_byte;
                default: ;
            endcase
        end
    end

endmodule

[rtl/ps2mpc_queue.sv]
module ps2mpc_queue #(
    parameter int P_DEPTH = ps2mpc_pkg::QUEUE_DEPTH
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  ps2mpc_pkg::t_entry  i_entry,
    output logic                o_full,
    output logic                o_valid,
    output ps2mpc_pkg::t_entry  o_entry,
    input  logic                i_pop
);

    localparam int PW = (P_DEPTH > 1) ? $clog2(P_DEPTH) : 1;
    localparam int CW = $clog2(P_DEPTH + 1);

    ps2mpc_pkg::t_entry r_mem [P_DEPTH];
    logic [PW-1:0] r_wr;
    logic [PW-1:0] r_rd;
    logic [CW-1:0] r_count;
    logic [PW-1:0] n_wr;
    logic [PW-1:0] n_rd;
    logic [CW-1:0] n_count;
    logic          do_push;
    logic          do_pop;

    assign o_full  = (r_count == CW'(P_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_entry = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (do_push) begin
            n_wr = (r_wr == PW'(P_DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (do_pop) begin
            n_rd = (r_rd == PW'(P_DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        case ({do_push, do_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

endmodule

[rtl/ps2mpc_back.sv]
module ps2mpc_back #(
    parameter int P_SCROLL_DIVISOR = ps2mpc_pkg::SCROLL_DIVISOR
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  ps2mpc_pkg::t_cfg                  i_cfg,
    input  logic                              i_valid,
    input  ps2mpc_pkg::t_entry                i_entry,
    output logic                              o_pop,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic                              o_cause,
    output logic [ps2mpc_pkg::BUTTON_W-1:0]   o_buttons,
    output logic signed [ps2mpc_pkg::SUM_W-1:0] o_move_x,
    output logic signed [ps2mpc_pkg::SUM_W-1:0] o_move_y,
    output logic signed [ps2mpc_pkg::SUM_W-1:0] o_scroll
);

    localparam int SW        = ps2mpc_pkg::SUM_W;
    localparam int BW        = ps2mpc_pkg::BUTTON_W;
    localparam int REM_W     = $clog2(P_SCROLL_DIVISOR) + 1;
    localparam int ACC_W     = 10;
    localparam int MAG_W     = 9;
    localparam int REC_SHIFT = 18;
    localparam int REC_MULT  = ((1 << REC_SHIFT) + P_SCROLL_DIVISOR - 1) / P_SCROLL_DIVISOR;
    localparam int PROD_W    = MAG_W + REC_SHIFT;

    logic [SW-1:0]          r_sum_x;
    logic [SW-1:0]          r_sum_y;
    logic [SW-1:0]          r_sum_s;
    logic [BW-1:0]          r_last_btn;
    logic                   r_pending;
    logic                   r_gesture;
    logic [REM_W-1:0]       r_rem;
    logic                   r_out_valid;
    logic                   r_out_cause;
    logic [BW-1:0]          r_out_btn;
    logic [SW-1:0]          r_out_x;
    logic [SW-1:0]          r_out_y;
    logic [SW-1:0]          r_out_s;

    logic [SW-1:0]          n_sum_x;
    logic [SW-1:0]          n_sum_y;
    logic [SW-1:0]          n_sum_s;
    logic [BW-1:0]          n_last_btn;
    logic                   n_pending;
    logic                   n_gesture;
    logic [REM_W-1:0]       n_rem;
    logic                   n_out_valid;

    logic                   take;
    logic                   emit;
    logic                   emit_cause;
    logic                   both_held;
    logic                   flush;
    logic [SW-1:0]          base_x;
    logic [SW-1:0]          base_y;
    logic [SW-1:0]          base_s;
    logic [SW-1:0]          dx_ext;
    logic [SW-1:0]          dy_ext;
    logic [SW-1:0]          wheel_ext;

    logic [REM_W-1:0]       rem_base;
    logic [ACC_W-1:0]       acc;
    logic                   acc_neg;
    logic [ACC_W-1:0]       acc_abs;
    logic [MAG_W-1:0]       mag;
    logic [PROD_W-1:0]      prod;
    logic [MAG_W-1:0]       quo;
    logic [PROD_W-1:0]      quo_times_d;
    logic [MAG_W-1:0]       rmag;
    logic [MAG_W-1:0]       rmag_signed;
    logic [SW-1:0]          ticks_ext;

    assign take  = i_valid && !(r_out_valid && i_stall);
    assign o_pop = take;

    // Gesture division: truncating divide of a small signed value by a constant,
    // done on the magnitude through an exact reciprocal multiply.
    always_comb begin
        rem_base    = r_gesture ? r_rem : '0;
        acc         = {{(ACC_W - REM_W){rem_base[REM_W-1]}}, rem_base} +
                      {{(ACC_W - 9){i_entry.dy[8]}}, i_entry.dy};
        acc_neg     = acc[ACC_W-1];
        acc_abs     = acc_neg ? (~acc + 1'b1) : acc;
        mag         = acc_abs[MAG_W-1:0];
        prod        = PROD_W'(mag) * PROD_W'(REC_MULT);
        quo         = prod[REC_SHIFT +: MAG_W];
        quo_times_d = PROD_W'(quo) * PROD_W'(P_SCROLL_DIVISOR);
        rmag        = mag - quo_times_d[MAG_W-1:0];
        rmag_signed = acc_neg ? (~rmag + 1'b1) : rmag;
        ticks_ext   = acc_neg ? (~SW'(quo) + 1'b1) : SW'(quo);
    end

    always_comb begin
        both_held = i_entry.buttons[0] && i_entry.buttons[1];
        flush     = r_pending && (i_entry.buttons != r_last_btn);
        dx_ext    = {{(SW - 9){i_entry.dx[8]}}, i_entry.dx};
        dy_ext    = {{(SW - 9){i_entry.dy[8]}}, i_entry.dy};
        wheel_ext = {{(SW - 8){i_entry.wheel[7]}}, i_entry.wheel};
        base_x    = flush ? '0 : r_sum_x;
        base_y    = flush ? '0 : r_sum_y;
        base_s    = flush ? '0 : r_sum_s;

        n_sum_x    = r_sum_x;
        n_sum_y    = r_sum_y;
        n_sum_s    = r_sum_s;
        n_last_btn = r_last_btn;
        n_pending  = r_pending;
        n_gesture  = r_gesture;
        n_rem      = r_rem;
        emit       = 1'b0;
        emit_cause = ps2mpc_pkg::CAUSE_DRAIN;

        if (take) begin
            if (i_entry.kind == ps2mpc_pkg::KIND_DRAIN) begin
                emit       = r_pending;
                emit_cause = ps2mpc_pkg::CAUSE_DRAIN;
                n_sum_x    = '0;
                n_sum_y    = '0;
                n_sum_s    = '0;
                n_pending  = 1'b0;
            end else if (both_held) begin
                n_gesture = 1'b1;
                n_rem     = rmag_signed[REM_W-1:0];
                if (quo != '0) begin
                    n_sum_s   = r_sum_s + ticks_ext;
                    n_pending = 1'b1;
                end
            end else if (r_gesture) begin
                // The first packet after the gesture only resyncs the buttons.
                n_gesture  = 1'b0;
                n_rem      = '0;
                n_last_btn = i_entry.buttons;
                n_pending  = 1'b1;
            end else begin
                emit       = flush;
                emit_cause = ps2mpc_pkg::CAUSE_BUTTON;
                n_sum_x    = base_x + dx_ext;
                n_sum_y    = base_y - dy_ext;
                n_sum_s    = base_s + wheel_ext;
                n_last_btn = i_entry.buttons;
                n_pending  = 1'b1;
            end
        end

        n_out_valid = r_out_valid && i_stall;
        if (emit && i_cfg.deliver_enable) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum_x     <= '0;
            r_sum_y     <= '0;
            r_sum_s     <= '0;
            r_last_btn  <= '0;
            r_pending   <= 1'b0;
            r_gesture   <= 1'b0;
            r_rem       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_sum_x     <= n_sum_x;
            r_sum_y     <= n_sum_y;
            r_sum_s     <= n_sum_s;
            r_last_btn  <= n_last_btn;
            r_pending   <= n_pending;
            r_gesture   <= n_gesture;
            r_rem       <= n_rem;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit && i_cfg.deliver_enable) begin
            r_out_cause <= emit_cause;
            r_out_btn   <= r_last_btn;
            r_out_x     <= r_sum_x;
            r_out_y     <= r_sum_y;
            r_out_s     <= r_sum_s;
        end
    end

    assign o_valid   = r_out_valid;
    assign o_cause   = r_out_cause;
    assign o_buttons = r_out_btn;
    assign o_move_x  = r_out_x;
    assign o_move_y  = r_out_y;
    assign o_scroll  = r_out_s;

endmodule

[rtl/ps2_mouse_packet_coalescer.sv]
// PS/2 mouse packet coalescer.
// Input channel (i_in_valid / o_in_stall): one item per accepted cycle, either a
// raw mouse byte (i_op = data) or a drain-end marker (i_op = drain).
// Output channel (o_out_valid / i_out_stall): coalesced motion events, flushed on a
// button change or at drain end. Both take one item per clock edge unless stalled.
// The front end assembles 3- or 4-byte packets and resyncs on bad head bytes; a
// two-entry queue feeds the back end, which keeps the motion sums and the
// two-button scroll gesture.
// Throughput: one input item per cycle, sustained while results are taken.
// The queue is written at the edge that accepts an input item; o_out_valid rises
// when the back end takes that entry from the queue and loads the output register.
// When the receiver stalls, the output register holds its item and the back end
// takes no queue entries until that item is taken; o_in_stall rises once the
// queue is full.
// Reset (i_rst_n low, synchronous) clears the packet position, the sums, the
// flags and both configuration registers; no clearing pass is needed.
// Configuration: wheel_enabled at address 0, deliver_enable at address 4.
module ps2_mouse_packet_coalescer #(
    parameter int P_SCROLL_DIVISOR = ps2mpc_pkg::SCROLL_DIVISOR
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  logic                                  i_op,
    input  logic [7:0]                            i_data_byte,
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output logic                                  o_cause,
    output logic [ps2mpc_pkg::BUTTON_W-1:0]       o_buttons,
    output logic signed [ps2mpc_pkg::SUM_W-1:0]   o_move_x,
    output logic signed [ps2mpc_pkg::SUM_W-1:0]   o_move_y,
    output logic signed [ps2mpc_pkg::SUM_W-1:0]   o_scroll,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [2:0]                            paddr,
    input  logic [31:0]                           pwdata,
    output logic [31:0]                           prdata,
    output logic                                  pready
);

    logic               r_wheel_enabled;
    logic               r_deliver_enable;
    logic               cfg_write;
    ps2mpc_pkg::t_cfg   cfg;

    logic               w_push;
    logic               w_full;
    logic               w_q_valid;
    logic               w_pop;
    ps2mpc_pkg::t_entry w_front_entry;
    ps2mpc_pkg::t_entry w_back_entry;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wheel_enabled  <= 1'b0;
            r_deliver_enable <= 1'b0;
        end else if (cfg_write) begin
            unique case (paddr[2])
                ps2mpc_pkg::REG_WHEEL_ENABLED:  r_wheel_enabled  <= pwdata[0];
                ps2mpc_pkg::REG_DELIVER_ENABLE: r_deliver_enable <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            ps2mpc_pkg::REG_WHEEL_ENABLED:  prdata = {31'd0, r_wheel_enabled};
            ps2mpc_pkg::REG_DELIVER_ENABLE: prdata = {31'd0, r_deliver_enable};
            default:                        prdata = 32'd0;
        endcase
    end

    assign cfg.wheel_enabled  = r_wheel_enabled;
    assign cfg.deliver_enable = r_deliver_enable;

    ps2mpc_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_in_valid),
        .o_stall      (o_in_stall),
        .i_op         (i_op),
        .i_data_byte  (i_data_byte),
        .i_cfg        (cfg),
        .i_queue_full (w_full),
        .o_push       (w_push),
        .o_entry      (w_front_entry)
    );

    ps2mpc_queue #(
        .P_DEPTH (ps2mpc_pkg::QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_entry (w_front_entry),
        .o_full  (w_full),
        .o_valid (w_q_valid),
        .o_entry (w_back_entry),
        .i_pop   (w_pop)
    );

    ps2mpc_back #(
        .P_SCROLL_DIVISOR (P_SCROLL_DIVISOR)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (cfg),
        .i_valid   (w_q_valid),
        .i_entry   (w_back_entry),
        .o_pop     (w_pop),
        .o_valid   (o_out_valid),
        .i_stall   (i_out_stall),
        .o_cause   (o_cause),
        .o_buttons (o_buttons),
        .o_move_x  (o_move_x),
        .o_move_y  (o_move_y),
        .o_scroll  (o_scroll)
    );

    // A new result can only come from a queue entry taken on the previous edge.
    a_out_from_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(w_pop))
        else $error("result appeared without a queue entry being taken");

    // The input side only stalls when the queue holds entries for the back end.
    a_stall_means_queued: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> w_q_valid)
        else $error("input stalled while the queue is empty");

    // Suppressed delivery must never raise a result.
    a_deliver_gate: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_deliver_enable))
        else $error("result raised while delivery was disabled");

endmodule
